// ===== rtl/core/image_mean_squared_error_assert.svh =====
// Assertion macros shared by the image MSE block.
`ifndef IMAGE_MEAN_SQUARED_ERROR_ASSERT_SVH
`define IMAGE_MEAN_SQUARED_ERROR_ASSERT_SVH
`ifndef SYNTHESIS
`define IMSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define IMSE_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define IMSE_ASSERT(label, clk, rst, prop)
`define IMSE_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/core/imse_pkg.sv =====
package imse_pkg;

   localparam int FIELD_BITS  = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 22;
   localparam int MASK_BITS   = 8;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS;
   localparam int TERM_BITS   = SQ_BITS + MASK_BITS;
   localparam int ERR_BITS    = 64;
   localparam int WEIGHT_BITS = COUNT_BITS + MASK_BITS;
   localparam int DEN_BITS    = WEIGHT_BITS + 2;
   localparam int FRAC_BITS   = 8;
   localparam int NUM_BITS    = ERR_BITS + FRAC_BITS + 1;
   localparam int MSE_BITS    = 40;
   localparam int STEP_BITS   = $clog2(NUM_BITS);

   localparam logic [WEIGHT_BITS-1:0] COUNT_CAP =
      WEIGHT_BITS'((longint'(1) << COUNT_BITS) - 1);
   localparam logic [WEIGHT_BITS-1:0] MASK_CAP =
      WEIGHT_BITS'(((longint'(1) << COUNT_BITS) - 1) * ((longint'(1) << MASK_BITS) - 1));

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_MEAN3  = 2'd1;
   localparam logic [1:0] MODE_SELECT = 2'd2;

   localparam logic [1:0] CHAN_0 = 2'd0;
   localparam logic [1:0] CHAN_1 = 2'd1;
   localparam logic [1:0] CHAN_2 = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_USE_MASK = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] channel_select;
      logic       use_mask;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic last_done;
   } dp_status_type;

endpackage

// ===== rtl/core/imse_csr.sv =====
module imse_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [imse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [imse_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output imse_pkg::cfg_type                     cfg
);
   import imse_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:     cfg_in.mode           = csr_data[1:0];
            REG_CHANNEL:  cfg_in.channel_select = csr_data[1:0];
            REG_USE_MASK: cfg_in.use_mask       = csr_data[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/imse_ctrl.sv =====
`include "image_mean_squared_error_assert.svh"

module imse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    last_pixel,
   output logic                    busy,
   output logic                    rsp_valid,
   output imse_pkg::dp_cmd_type    cmd,
   input  imse_pkg::dp_status_type status
);
   import imse_pkg::*;

   typedef enum logic [4:0] {
      ST_RUN   = 5'b00001,
      ST_FLUSH = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic [STEP_BITS-1:0]  step_cnt_ff;
   logic [STEP_BITS-1:0]  step_cnt_in;

   assign busy       = (state_ff != ST_RUN);
   assign cmd.accept = start && (state_ff == ST_RUN);
   assign cmd.load   = (state_ff == ST_LOAD);
   assign cmd.step   = (state_ff == ST_DIV);
   assign cmd.emit   = (state_ff == ST_EMIT);
   assign rsp_valid  = cmd.emit;

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.accept && last_pixel) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // hold until the final pixel has reached the accumulators
            if (status.last_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            step_cnt_in = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            step_cnt_in = step_cnt_ff + 1'b1;
            if (step_cnt_ff == STEP_BITS'(NUM_BITS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   `IMSE_ASSERT(a_last_blocks_input, clock, reset, cmd.accept && last_pixel |=> busy)
   `IMSE_ASSERT(a_emit_one_beat, clock, reset, rsp_valid |=> !rsp_valid)
   `IMSE_NEVER(a_step_count_range, clock, reset, cmd.step && (step_cnt_ff >= STEP_BITS'(NUM_BITS)))

endmodule

// ===== rtl/core/imse_dp.sv =====
`include "image_mean_squared_error_assert.svh"

module imse_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  imse_pkg::cfg_type                   cfg,
   input  imse_pkg::dp_cmd_type                cmd,
   output imse_pkg::dp_status_type             status,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] ref_c0,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] ref_c1,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] ref_c2,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] test_c0,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] test_c1,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] test_c2,
   input  logic [imse_pkg::MASK_BITS-1:0]      mask_weight,
   input  logic                                last_pixel,
   output logic [imse_pkg::MSE_BITS-1:0]       mse_value,
   output logic                                empty_set,
   output logic                                saturated
);
   import imse_pkg::*;

   function automatic logic [SAMPLE_BITS-1:0] abs_diff(
      input logic [FIELD_BITS-1:0] a,
      input logic [FIELD_BITS-1:0] b
   );
      logic signed [SAMPLE_BITS:0] diff;
      logic        [SAMPLE_BITS:0] neg;
      diff = signed'({a[SAMPLE_BITS-1], a[SAMPLE_BITS-1:0]})
           - signed'({b[SAMPLE_BITS-1], b[SAMPLE_BITS-1:0]});
      neg  = -diff;
      return diff[SAMPLE_BITS] ? neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
   endfunction

   // stage 1: magnitudes of the sample differences
   logic                   v1_ff, last1_ff;
   cfg_type                cfg1_ff;
   logic [MASK_BITS-1:0]   mask1_ff;
   logic [SAMPLE_BITS-1:0] mag_ff [3];

   // stage 2: squares
   logic                   v2_ff, last2_ff;
   cfg_type                cfg2_ff;
   logic [MASK_BITS-1:0]   mask2_ff;
   logic [SQ_BITS-1:0]     sq_ff [3];

   // stage 3: per-pixel error term and weight increment
   logic                   v3_ff, last3_ff, mean3_ff, masked3_ff;
   logic [TERM_BITS-1:0]   term_ff, term_in;
   logic [MASK_BITS-1:0]   inc_ff, inc_in;
   logic                   masked_in;
   logic [SQ_BITS-1:0]     sel_sq;

   // accumulators
   logic [ERR_BITS-1:0]    es_ff, es_in;
   logic [WEIGHT_BITS-1:0] ws_ff, ws_in;
   logic                   last_done_ff;
   logic                   mean_last_ff;
   logic [ERR_BITS:0]      es_wide;
   logic [WEIGHT_BITS:0]   ws_wide;
   logic [WEIGHT_BITS-1:0] cap;

   // divider
   logic [DEN_BITS-1:0]    den_ff, den_in;
   logic [DEN_BITS-1:0]    rem_ff, rem_in;
   logic [NUM_BITS-1:0]    num_ff, num_in;
   logic [MSE_BITS-1:0]    quot_ff, quot_in;
   logic                   ovf_ff, ovf_in;
   logic                   empty_ff;
   logic [DEN_BITS:0]      trial;
   logic [DEN_BITS:0]      trial_diff;
   logic                   fits;

   assign status.last_done = last_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff  <= last_pixel;
      cfg1_ff   <= cfg;
      mask1_ff  <= mask_weight;
      mag_ff[0] <= abs_diff(ref_c0, test_c0);
      mag_ff[1] <= abs_diff(ref_c1, test_c1);
      mag_ff[2] <= abs_diff(ref_c2, test_c2);

      last2_ff  <= last1_ff;
      cfg2_ff   <= cfg1_ff;
      mask2_ff  <= mask1_ff;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= SQ_BITS'(mag_ff[i]) * SQ_BITS'(mag_ff[i]);
      end

      last3_ff   <= last2_ff;
      mean3_ff   <= (cfg2_ff.mode == MODE_MEAN3);
      masked3_ff <= masked_in;
      term_ff    <= term_in;
      inc_ff     <= inc_in;
   end

   always_comb begin
      case (cfg2_ff.channel_select)
         CHAN_1:  sel_sq = sq_ff[1];
         CHAN_2:  sel_sq = sq_ff[2];
         default: sel_sq = sq_ff[0];
      endcase
   end

   always_comb begin
      term_in   = TERM_BITS'(sq_ff[0]);
      inc_in    = MASK_BITS'(1);
      masked_in = 1'b0;
      unique case (cfg2_ff.mode)
         MODE_MEAN3: begin
            term_in = TERM_BITS'(sq_ff[0]) + TERM_BITS'(sq_ff[1]) + TERM_BITS'(sq_ff[2]);
         end
         MODE_SELECT: begin
            if (cfg2_ff.use_mask) begin
               term_in   = TERM_BITS'(sel_sq) * TERM_BITS'(mask2_ff);
               inc_in    = mask2_ff;
               masked_in = 1'b1;
            end else begin
               term_in = TERM_BITS'(sel_sq);
            end
         end
         default: begin
            term_in = TERM_BITS'(sq_ff[0]);
         end
      endcase
   end

   // saturating accumulation
   always_comb begin
      es_wide = {1'b0, es_ff} + (ERR_BITS + 1)'(term_ff);
      ws_wide = {1'b0, ws_ff} + (WEIGHT_BITS + 1)'(inc_ff);
      cap     = masked3_ff ? MASK_CAP : COUNT_CAP;
      es_in   = es_ff;
      ws_in   = ws_ff;
      if (cmd.load) begin
         es_in = '0;
         ws_in = '0;
      end else if (v3_ff) begin
         es_in = es_wide[ERR_BITS] ? '1 : es_wide[ERR_BITS-1:0];
         if (ws_wide > {1'b0, cap}) begin
            ws_in = (ws_ff > cap) ? ws_ff : cap;
         end else begin
            ws_in = ws_wide[WEIGHT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         es_ff        <= '0;
         ws_ff        <= '0;
         last_done_ff <= 1'b0;
      end else begin
         es_ff        <= es_in;
         ws_ff        <= ws_in;
         last_done_ff <= v3_ff && last3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && last3_ff) begin
         mean_last_ff <= mean3_ff;
      end
   end

   // restoring divider on (sum * 256 + den / 2) / den, one quotient bit a beat
   always_comb begin
      trial      = {rem_ff, num_ff[NUM_BITS-1]};
      trial_diff = trial - {1'b0, den_ff};
      fits       = (trial >= {1'b0, den_ff});
      den_in     = den_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      quot_in    = quot_ff;
      ovf_in     = ovf_ff;
      if (cmd.load) begin
         den_in  = mean_last_ff ? (DEN_BITS'(ws_ff) + DEN_BITS'({ws_ff, 1'b0}))
                                : DEN_BITS'(ws_ff);
         num_in  = NUM_BITS'({es_ff, FRAC_BITS'(0)}) + NUM_BITS'(den_in >> 1);
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
      end else if (cmd.step) begin
         rem_in  = fits ? trial_diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         num_in  = {num_ff[NUM_BITS-2:0], 1'b0};
         quot_in = {quot_ff[MSE_BITS-2:0], fits};
         // any bit pushed out of the top means the quotient is out of range
         ovf_in  = ovf_ff | quot_ff[MSE_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      if (cmd.load) begin
         empty_ff <= (den_in == '0);
      end
   end

   assign empty_set = empty_ff;
   assign saturated = !empty_ff && ovf_ff;
   assign mse_value = empty_ff ? '0 : (ovf_ff ? '1 : quot_ff);

   `IMSE_ASSERT(a_empty_gives_zero, clock, reset, cmd.emit && empty_set |-> mse_value == '0 && !saturated)
   `IMSE_ASSERT(a_load_clears_sums, clock, reset, cmd.load |=> es_ff == '0 && ws_ff == '0)

endmodule

// ===== rtl/core/image_mean_squared_error.sv =====
// Image mean squared error. Pixels arrive one per cycle on req_* and are taken on each
// clock edge with start high and busy low; squared differences and the pixel count (or
// mask weight sum) are accumulated through a four-stage pipeline. The pixel marked
// last_pixel raises busy: the pipeline drains, one 73-step radix-2 divider forms
// round(sum * 256 / den), den being the count tripled in the three-channel mean mode,
// and the result appears on rsp_* for exactly one cycle with rsp_valid. The receiver
// cannot stall that beat, so it must sample it when rsp_valid is high. The next
// image's first pixel can be taken from the edge after the one that ends the strobe;
// the drain and the divider set the per-image overhead, all other pixels go at one
// per cycle. Registers on csr_* are always ready and are to be written only while no
// image is in progress.
module image_mean_squared_error (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] req_ref_c0,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] req_ref_c1,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] req_ref_c2,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] req_test_c0,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] req_test_c1,
   input  logic signed [imse_pkg::FIELD_BITS-1:0] req_test_c2,
   input  logic [imse_pkg::MASK_BITS-1:0]        req_mask_weight,
   input  logic                                  req_last_pixel,
   output logic                                  rsp_valid,
   output logic [imse_pkg::MSE_BITS-1:0]         rsp_mse_value,
   output logic                                  rsp_empty_set,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [imse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [imse_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import imse_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   imse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   imse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_pixel (req_last_pixel),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .status     (status)
   );

   imse_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .ref_c0      (req_ref_c0),
      .ref_c1      (req_ref_c1),
      .ref_c2      (req_ref_c2),
      .test_c0     (req_test_c0),
      .test_c1     (req_test_c1),
      .test_c2     (req_test_c2),
      .mask_weight (req_mask_weight),
      .last_pixel  (req_last_pixel),
      .mse_value   (rsp_mse_value),
      .empty_set   (rsp_empty_set),
      .saturated   (rsp_saturated)
   );

endmodule
